// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the dedup filter; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication on i_clk, quiet while i_rst_n is low
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sdf_pkg.sv =====
// ---------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the stream dedup filter.
// ---------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int VALUE_W         = 32;
    localparam int UCOUNT_W        = 8;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_set;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_out;
        logic                       is_unique;
        logic        [UCOUNT_W-1:0] unique_count;
        logic                       overflow;
        logic                       set_done;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the input item, restart the scan
        logic scan;     // step the table scan
        logic finish;   // form the result, append if new
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/sdf_dp.sv =====
// ---------------------------------------------------------------------------
// sdf_dp
// Datapath: seen-value table, scan counter, compare and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sdf_dp #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sdf_pkg::t_in  i_in,
    input  wire sdf_pkg::t_cmd i_cmd,
    output sdf_pkg::t_sts      o_sts,
    output logic               o_valid,
    output sdf_pkg::t_out      o_out
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [sdf_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [sdf_pkg::VALUE_W-1:0] r_rd_data;
    sdf_pkg::t_in                r_item;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_scan;
    logic                        r_pend;
    logic                        r_hit;
    logic                        r_valid;
    sdf_pkg::t_out               r_out, n_out;

    logic          full;
    logic          issue;
    logic          wr_en;
    logic [CW-1:0] count_new;

    assign full  = (r_count == DEPTH_C);
    assign issue = i_cmd.scan && !r_hit && (r_scan != r_count);
    assign wr_en = i_cmd.finish && !r_hit && !full;
    assign count_new = wr_en ? r_count + CW'(1) : r_count;

    assign o_sts.scan_done = (r_hit || (r_scan == r_count)) && !r_pend;

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= r_item.value;
        end
        r_rd_data <= mem[r_scan[AW-1:0]];
    end

    always_comb begin
        n_out              = r_out;
        n_out.value_out    = r_item.value;
        n_out.is_unique    = !r_hit;
        n_out.unique_count = sdf_pkg::UCOUNT_W'(count_new);
        n_out.overflow     = !r_hit && full;
        n_out.set_done     = r_item.end_of_set;
        n_count            = r_item.end_of_set ? '0 : count_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_scan  <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_scan <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else begin
                // read issued this cycle is compared next cycle
                r_pend <= issue;
                if (issue) begin
                    r_scan <= r_scan + CW'(1);
                end
                if (r_pend && (r_rd_data == r_item.value)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    `ASSERT_IMPLY(a_set_clears, r_valid && r_out.set_done, r_count == '0, "count not cleared at end of set")
    `ASSERT_IMPLY(a_ovf_full, r_valid && r_out.overflow && !r_out.set_done, r_count == DEPTH_C, "overflow without full table")
    `ASSERT_IMPLY(a_pend_read, r_pend, r_scan != '0 && r_scan <= r_count, "compare without a prior read")

endmodule

`default_nettype wire

// ===== hw/rtl/sdf_ctrl.sv =====
// ---------------------------------------------------------------------------
// sdf_ctrl
// Controller: accepts an item, runs the table scan, then issues the result.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sdf_pkg::t_sts i_sts,
    output sdf_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd.load   = i_start && (r_state == ST_IDLE);
    assign o_cmd.scan   = (r_state == ST_SCAN);
    assign o_cmd.finish = (r_state == ST_FIN);
    assign o_busy       = r_busy;

endmodule

`default_nettype wire

// ===== hw/rtl/stream_dedup_filter.sv =====
// ---------------------------------------------------------------------------
// stream_dedup_filter
// Order-preserving duplicate removal over sets of signed 32-bit values.
// ---------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. Each item is
// checked against the distinct values already stored for the current set,
// one table entry per cycle through the table's single registered read
// port; the scan stops at the first match. Without a match busy stays high
// through one read per stored entry, the last compare, the cycle that
// sees the scan done and the one that forms the result. A match ends the
// scan early. A new item is taken only once busy has dropped. Exactly one
// result follows each item: o_valid is high for a single cycle and the
// result must be taken then, since the receiver cannot hold it off. busy
// drops in that same cycle, so the next item may start while the result is
// on the ports.
// A new value is appended to the table in first-seen order; with the table
// full it is reported unique with overflow set and is not stored. The item
// marked end_of_set clears the table once its result is formed. No clearing
// pass is needed after reset: only entries below the stored count are read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stream_dedup_filter #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire sdf_pkg::t_in i_in,
    output logic              o_valid,
    output sdf_pkg::t_out     o_out
);

    sdf_pkg::t_cmd cmd;
    sdf_pkg::t_sts sts;

    // sequencing: idle -> scan -> finish
    sdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // table, scan counter, compare, result register
    sdf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // accepted transfer keeps the block busy until its result
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after a transfer")
    // a result only appears as the block frees up
    `ASSERT_IMPLY(a_valid_idle, o_valid, !busy, "result while still busy")
    `ASSERT_NEXT(a_finish_valid, cmd.finish, o_valid, "finish without a result strobe")

endmodule

`default_nettype wire

// ===== tb/stream_dedup_filter_checker.sv =====
// ---------------------------------------------------------------------------
// stream_dedup_filter_checker
// Watches the command and result channels of the dedup filter, predicts the
// result of every accepted item and compares it field by field.
// ---------------------------------------------------------------------------
module stream_dedup_filter_checker #(
    parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  sdf_pkg::t_in  i_in,
    input  logic          i_valid,
    input  sdf_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // distinct values of the current set, first-seen order
    logic signed [sdf_pkg::VALUE_W-1:0] seen_vals [TABLE_DEPTH];
    int                                 n_seen;
    sdf_pkg::t_out                      classified_q [$];
    int                                 fail_count;
    int                                 pending_cnt;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    function automatic sdf_pkg::t_out classify_value(input sdf_pkg::t_in item);
        sdf_pkg::t_out r;
        logic          hit;
        hit = 1'b0;
        for (int i = 0; i < n_seen; i++) begin
            if (seen_vals[i] == item.value) hit = 1'b1;
        end
        r.value_out = item.value;
        r.is_unique = !hit;
        r.overflow  = 1'b0;
        if (!hit) begin
            if (n_seen < TABLE_DEPTH) begin
                seen_vals[n_seen] = item.value;
                n_seen++;
            end else begin
                r.overflow = 1'b1;
            end
        end
        // count is reported before the end-of-set clear
        r.unique_count = sdf_pkg::UCOUNT_W'(n_seen);
        r.set_done     = item.end_of_set;
        if (item.end_of_set) n_seen = 0;
        return r;
    endfunction

    initial begin
        n_seen      = 0;
        fail_count  = 0;
        pending_cnt = 0;
    end

    always @(posedge i_clk) begin
        sdf_pkg::t_out exp_r;
        if (!i_rst_n) begin
            n_seen = 0;
            classified_q.delete();
        end else begin
            // result leaves before a transfer in the same cycle can be answered
            if (i_valid) begin
                if (classified_q.size() == 0) begin
                    $error("unexpected result: value_out %0d", i_out.value_out);
                    fail_count++;
                end else begin
                    exp_r = classified_q.pop_front();
                    if (i_out.value_out !== exp_r.value_out) begin
                        $error("value_out: expected %0d actual %0d",
                               exp_r.value_out, i_out.value_out);
                        fail_count++;
                    end
                    if (i_out.is_unique !== exp_r.is_unique) begin
                        $error("is_unique: expected %0d actual %0d",
                               exp_r.is_unique, i_out.is_unique);
                        fail_count++;
                    end
                    if (i_out.unique_count !== exp_r.unique_count) begin
                        $error("unique_count: expected %0d actual %0d",
                               exp_r.unique_count, i_out.unique_count);
                        fail_count++;
                    end
                    if (i_out.overflow !== exp_r.overflow) begin
                        $error("overflow: expected %0d actual %0d",
                               exp_r.overflow, i_out.overflow);
                        fail_count++;
                    end
                    if (i_out.set_done !== exp_r.set_done) begin
                        $error("set_done: expected %0d actual %0d",
                               exp_r.set_done, i_out.set_done);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) classified_q.push_back(classify_value(i_in));
        end
        pending_cnt = classified_q.size();
    end

endmodule

// ===== tb/stream_dedup_filter_tb.sv =====
// ---------------------------------------------------------------------------
// stream_dedup_filter_tb
// Drives sets of signed values into the dedup filter with random gaps; the
// checker predicts every result and counts mismatches for the verdict.
// ---------------------------------------------------------------------------
module stream_dedup_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF;
    localparam int N_ITEMS     = 1200;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    sdf_pkg::t_in  in_item;
    logic          res_valid;
    sdf_pkg::t_out res_item;
    int            fail_count;
    int            pending;

    int            items_sent;
    logic          no_gaps;     // burst stretch: back-to-back transfers

    stream_dedup_filter #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (in_item),
        .o_valid (res_valid),
        .o_out   (res_item)
    );

    stream_dedup_filter_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in         (in_item),
        .i_valid      (res_valid),
        .i_out        (res_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: worst case is ~1300 items at a full-table scan plus long gaps
    initial begin
        #12_000_000;
        $display("FAIL stream_dedup_filter");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 15);
        if (r == 0) return $urandom_range(20, 60);
        if (r < 7)  return 0;
        return $urandom_range(1, 3);
    endfunction

    // One transfer. start stays high across back-to-back items; it is only
    // lowered when a gap follows, so it never gets two updates in one step.
    task automatic send_item(input logic signed [31:0] v, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        in_item.value      <= v;
        in_item.end_of_set <= eos;
        // transfer happens at the first edge with busy low
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // Short set drawn from a small pool so repeats are common; a few
    // items are fully random noise.
    task automatic run_short_set();
        logic signed [31:0] pool [6];
        logic signed [31:0] v;
        int                 len;
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(0, 3))
                0:       pool[i] = $signed($urandom_range(0, 8)) - 4;
                1:       pool[i] = $urandom_range(0, 1) ? 32'sh7fff_ffff
                                                        : 32'sh8000_0000;
                default: pool[i] = $urandom;
            endcase
        end
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) v = $urandom;
            else v = pool[$urandom_range(0, 5)];
            send_item(v, k == len - 1);
        end
    endtask

    // Fills the table to its depth with distinct values (odd stride keeps
    // them distinct), mixing in repeats for long scans; the tail then hits
    // the full table with stored repeats, new values that overflow, and
    // repeats of those overflowed values.
    task automatic run_long_set();
        logic [31:0]        base;
        logic [31:0]        stride;
        logic signed [31:0] v;
        int                 n_new;
        int                 tail;
        base   = $urandom;
        stride = $urandom | 32'd1;
        n_new  = 0;
        while (n_new < TABLE_DEPTH) begin
            if (n_new > 0 && $urandom_range(0, 7) == 0) begin
                send_item(base + $urandom_range(0, n_new - 1) * stride, 1'b0);
            end else begin
                send_item(base + n_new * stride, 1'b0);
                n_new++;
            end
        end
        tail = $urandom_range(10, 40);
        for (int k = 0; k < tail; k++) begin
            case ($urandom_range(0, 2))
                0:       v = base + $urandom_range(0, TABLE_DEPTH - 1) * stride;
                1:       v = base + (TABLE_DEPTH + $urandom_range(0, 3)) * stride;
                default: v = $urandom;
            endcase
            send_item(v, k == tail - 1);
        end
    endtask

    initial begin
        int set_idx;
        rst_n      = 1'b0;
        start      = 1'b0;
        in_item    = '0;
        items_sent = 0;
        no_gaps    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, repeats of extremes, end of set on a duplicate
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sd1,        1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(-32'sd1,        1'b0);
        send_item(32'sh0000_0001, 1'b0);
        send_item(32'sh7fff_ffff, 1'b1);
        // table must be empty again: single-item set
        send_item(32'sh8000_0000, 1'b1);
        // alternating bit patterns
        no_gaps = 1'b1;
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shaaaa_aaaa, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shaaaa_aaaa, 1'b1);
        // one value repeated through a whole set
        send_item(32'sd42, 1'b0);
        send_item(32'sd42, 1'b0);
        send_item(32'sd42, 1'b1);
        no_gaps = 1'b0;
        send_item(-32'sd1, 1'b1);

        // random sets; every fiftieth one runs the table into overflow
        set_idx = 0;
        while (items_sent < N_ITEMS) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if (set_idx % 50 == 10) run_long_set();
            else run_short_set();
            set_idx++;
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        // drain: room for a stray result after a full-table scan
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS stream_dedup_filter");
        end else begin
            $display("FAIL stream_dedup_filter");
        end
        $finish;
    end

endmodule
